>>> sv/command_packet_receiver_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command packet receiver
// Shared forms of the concurrent checks, clocked on i_clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef COMMAND_PACKET_RECEIVER_TOP_DEFINES_SVH
`define COMMAND_PACKET_RECEIVER_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define CPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define CPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/cpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command packet receiver package
// Byte width and fixed frame constants of the command frame parser
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int unsigned BYTE_W = 8;

    typedef logic [BYTE_W-1:0] t_byte;

    // Header byte, largest valid action code and device id after reset
    localparam t_byte HEADER_BYTE = 8'hFF;
    localparam t_byte MAX_ACTION  = 8'd5;
    localparam t_byte ADDR_RESET  = 8'd11;

endpackage

>>> sv/command_packet_receiver_top.sv
// A result appears in the cycle after the checksum item is accepted.
// One item per cycle while the input is not stalled; the frame state and result register set this.
// The input is stalled only at the checksum position while a stalled result waits.
// Reset is synchronous, active low: device id 11, parser at first header byte.
`timescale 1ns / 1ps
`include "command_packet_receiver_top_defines.svh"
// ----------------------------------------------------------------------------
// Command packet receiver
// Parses a byte stream into command frames and emits one result per frame
// ----------------------------------------------------------------------------
module command_packet_receiver_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // received byte channel
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  cpr_pkg::t_byte       i_rx_byte,
    // result channel
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    output cpr_pkg::t_byte       o_action_code,
    output cpr_pkg::t_byte       o_direction_flag,
    output cpr_pkg::t_byte       o_value_whole,
    output cpr_pkg::t_byte       o_value_hundredths,
    output cpr_pkg::t_byte       o_checksum_computed,
    output cpr_pkg::t_byte       o_checksum_received,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    import cpr_pkg::*;

    // Frame position codes
    localparam logic [3:0] POS_NONE = 4'd0;
    localparam logic [3:0] POS_HDR1 = 4'd1;
    localparam logic [3:0] POS_HDR2 = 4'd2;
    localparam logic [3:0] POS_ID   = 4'd3;
    localparam logic [3:0] POS_ACT  = 4'd4;
    localparam logic [3:0] POS_DIR  = 4'd5;
    localparam logic [3:0] POS_VW   = 4'd6;
    localparam logic [3:0] POS_VH   = 4'd7;
    localparam logic [3:0] POS_CSUM = 4'd8;

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    t_byte      r_dev_addr;
    t_byte      r_seen_addr;
    t_byte      n_seen_addr;
    t_byte      r_action;
    t_byte      n_action;
    t_byte      r_dir;
    t_byte      r_vwhole;
    t_byte      r_vhund;
    logic       r_res_valid;
    t_byte      r_res_action;
    t_byte      r_res_dir;
    t_byte      r_res_vwhole;
    t_byte      r_res_vhund;
    t_byte      r_res_csum_calc;
    t_byte      r_res_csum_rx;

    logic       rx_accept;
    logic       cfg_write;
    logic       emit;
    t_byte      frame_sum;

    // Hold the input only when a checksum item would overwrite a waiting result
    assign o_rx_stall = r_res_valid && i_res_stall && (r_pos == POS_CSUM);
    assign rx_accept  = i_rx_valid && !o_rx_stall;
    assign emit       = rx_accept && (r_pos == POS_CSUM);

    // Register access: byte lanes ignored, one register at word 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {24'd0, r_dev_addr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_RESET;
        end else if (cfg_write) begin
            r_dev_addr <= pwdata[BYTE_W-1:0];
        end
    end

    // Next frame position and latched id and action
    always_comb begin
        n_pos       = r_pos;
        n_seen_addr = r_seen_addr;
        n_action    = r_action;
        case (r_pos)
            POS_NONE, POS_HDR1, POS_HDR2: begin
                n_pos = (i_rx_byte == HEADER_BYTE) ? r_pos + 4'd1 : POS_HDR1;
            end
            POS_ID: begin
                if (i_rx_byte == r_dev_addr) begin
                    n_seen_addr = i_rx_byte;
                    n_pos       = POS_ACT;
                end
            end
            POS_ACT: begin
                if (i_rx_byte <= MAX_ACTION) begin
                    n_action = i_rx_byte;
                end
                n_pos = POS_DIR;
            end
            POS_DIR, POS_VW, POS_VH: begin
                n_pos = r_pos + 4'd1;
            end
            default: begin
                n_pos = POS_HDR1;
            end
        endcase
    end

    // Advance the frame state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HDR1;
            r_seen_addr <= '0;
            r_action    <= '0;
        end else if (rx_accept) begin
            r_pos       <= n_pos;
            r_seen_addr <= n_seen_addr;
            r_action    <= n_action;
        end
    end

    // Capture the three data bytes
    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            if (r_pos == POS_DIR) r_dir    <= i_rx_byte;
            if (r_pos == POS_VW)  r_vwhole <= i_rx_byte;
            if (r_pos == POS_VH)  r_vhund  <= i_rx_byte;
        end
    end

    // Byte sum of id, action and data, wrapping at eight bits
    assign frame_sum = r_seen_addr + r_action + r_dir + r_vwhole + r_vhund;

    // Result valid: set on a checksum item, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (emit) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res_action    <= r_action;
            r_res_dir       <= r_dir;
            r_res_vwhole    <= r_vwhole;
            r_res_vhund     <= r_vhund;
            r_res_csum_calc <= ~frame_sum + 8'd1;
            r_res_csum_rx   <= i_rx_byte;
        end
    end

    assign o_res_valid         = r_res_valid;
    assign o_action_code       = r_res_action;
    assign o_direction_flag    = r_res_dir;
    assign o_value_whole       = r_res_vwhole;
    assign o_value_hundredths  = r_res_vhund;
    assign o_checksum_computed = r_res_csum_calc;
    assign o_checksum_received = r_res_csum_rx;

    // Checks
    `CPR_ASSERT_NEXT(a_emit_valid, emit, r_res_valid && r_pos == POS_HDR1,
        "checksum item did not produce a result")
    `CPR_ASSERT_SAME(a_stall_cause, o_rx_stall, r_res_valid && r_pos == POS_CSUM,
        "input stalled without a waiting result")
    `CPR_ASSERT_NEXT(a_wrong_id, rx_accept && r_pos == POS_ID && i_rx_byte != r_dev_addr,
        r_pos == POS_ID, "wrong id byte moved the parser")
    `CPR_ASSERT_NEXT(a_res_drop, r_res_valid && !i_res_stall && !emit, !r_res_valid,
        "taken result not retired")

endmodule
